// File: rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the tilt gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int REG_W           = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int CMD_W           = 3;

  localparam logic [REG_W-1:0] X_THR_RST = REG_W'(5000);
  localparam logic [REG_W-1:0] Y_THR_RST = REG_W'(4500);
  localparam logic [REG_W-1:0] BAND_RST  = REG_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_THR = 2'd0,
    CFG_Y_THR = 2'd1,
    CFG_BAND  = 2'd2
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_NEXT     = 3'd1,
    CMD_PREV     = 3'd2,
    CMD_VOL_UP   = 3'd3,
    CMD_VOL_DOWN = 3'd4
  } cmd_t;

  // pos/neg tilt flags of one axis
  typedef struct packed {
    logic pos;
    logic neg;
  } axis_flags_t;

  typedef struct packed {
    axis_flags_t flags;
    logic        enter_pos;
    logic        enter_neg;
  } judge_res_t;

endpackage

// File: rtl/tgc_axis_judge.sv
// ----------------------------------------------------------------------------
// tgc_axis_judge
// One axis step: tilt entry on either side with hysteresis, level clear.
// ----------------------------------------------------------------------------
module tgc_axis_judge #(
  parameter int SAMPLE_BITS = tgc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             en,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic [tgc_pkg::REG_W-1:0]        thr,
  input  logic [tgc_pkg::REG_W-1:0]        band,
  input  tgc_pkg::axis_flags_t             flags_in,
  output tgc_pkg::judge_res_t              res
);
  import tgc_pkg::*;

  localparam int CMP_W = ((SAMPLE_BITS > REG_W + 1) ? SAMPLE_BITS : REG_W + 1) + 1;

  logic signed [CMP_W-1:0] v_ext;
  logic signed [CMP_W-1:0] thr_pos;
  logic signed [CMP_W-1:0] thr_neg;
  logic signed [CMP_W-1:0] band_pos;
  logic signed [CMP_W-1:0] band_neg;

  assign v_ext    = CMP_W'(sample);
  assign thr_pos  = signed'({{(CMP_W-REG_W){1'b0}}, thr});
  assign thr_neg  = -thr_pos;
  assign band_pos = signed'({{(CMP_W-REG_W){1'b0}}, band});
  assign band_neg = -band_pos;

  always_comb begin
    res.flags     = flags_in;
    res.enter_pos = 1'b0;
    res.enter_neg = 1'b0;
    if (en) begin
      if (v_ext > thr_pos && !flags_in.pos) begin
        res.flags.pos = 1'b1;
        res.flags.neg = 1'b0;
        res.enter_pos = 1'b1;
      end else if (v_ext < thr_neg && !flags_in.neg) begin
        res.flags.pos = 1'b0;
        res.flags.neg = 1'b1;
        res.enter_neg = 1'b1;
      end else if (v_ext > band_neg && v_ext < band_pos) begin
        res.flags.pos = 1'b0;
        res.flags.neg = 1'b0;
      end
    end
  end

endmodule

// File: rtl/tilt_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// tilt_gesture_classifier_core
// Two-axis tilt detector with hysteresis that emits media commands.
// ----------------------------------------------------------------------------
// Path: an accepted input word is held in the input register, then in the result register.
// Throughput: one word per cycle while out_ready keeps up; tilt flags are updated in the same cycle
// the result register loads, so the next word sees them at once.
// Reset: flags cleared, thresholds back to 5000 / 4500 / band 500, no words held.
module tilt_gesture_classifier_core #(
  parameter int SAMPLE_BITS = tgc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     accel_x,
  input  logic signed [SAMPLE_BITS-1:0]     accel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tgc_pkg::CMD_W-1:0]         command,
  output logic                              right_lit,
  output logic                              left_lit,
  output logic                              forward_lit,
  output logic                              back_lit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgc_pkg::REG_W-1:0]         cfg_data
);
  import tgc_pkg::*;

  logic [REG_W-1:0] x_thr;
  logic [REG_W-1:0] y_thr;
  logic [REG_W-1:0] band;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;

  axis_flags_t x_flags;
  axis_flags_t y_flags;
  judge_res_t  x_res;
  judge_res_t  y_res;
  cmd_t        cmd_next;
  logic        load_out;

  assign cfg_ready = 1'b1;
  assign load_out  = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_thr <= X_THR_RST;
      y_thr <= Y_THR_RST;
      band  <= BAND_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_THR: x_thr <= cfg_data;
        CFG_Y_THR: y_thr <= cfg_data;
        CFG_BAND:  band  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x <= accel_x;
      s1_y <= accel_y;
    end
  end

  tgc_axis_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_x (
    .en       (!(y_flags.pos || y_flags.neg)),
    .sample   (s1_x),
    .thr      (x_thr),
    .band     (band),
    .flags_in (x_flags),
    .res      (x_res)
  );

  // Y is judged against the X flags after the X step
  tgc_axis_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_y (
    .en       (!(x_res.flags.pos || x_res.flags.neg)),
    .sample   (s1_y),
    .thr      (y_thr),
    .band     (band),
    .flags_in (y_flags),
    .res      (y_res)
  );

  always_comb begin
    cmd_next = CMD_NONE;
    if (x_res.enter_pos) begin
      cmd_next = CMD_NEXT;
    end else if (x_res.enter_neg) begin
      cmd_next = CMD_PREV;
    end
    if (y_res.enter_pos) begin
      cmd_next = CMD_VOL_UP;
    end else if (y_res.enter_neg) begin
      cmd_next = CMD_VOL_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_flags   <= '0;
      y_flags   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        x_flags <= x_res.flags;
        y_flags <= y_res.flags;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      command     <= cmd_next;
      right_lit   <= x_res.flags.pos;
      left_lit    <= x_res.flags.neg;
      forward_lit <= y_res.flags.pos;
      back_lit    <= y_res.flags.neg;
    end
  end

`ifndef ASSERT_OFF
  a_x_excl: assert property (@(posedge clk) disable iff (rst)
    !(x_flags.pos && x_flags.neg))
    else $error("right and left both held");

  a_axis_excl: assert property (@(posedge clk) disable iff (rst)
    !((x_flags.pos || x_flags.neg) && (y_flags.pos || y_flags.neg)))
    else $error("X and Y tilt held together");

  a_cmd_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_NEXT) |-> right_lit && !forward_lit && !back_lit)
    else $error("next command without right tilt");

  a_flags_follow: assert property (@(posedge clk) disable iff (rst)
    load_out |=> right_lit == x_flags.pos && back_lit == y_flags.neg)
    else $error("indicators differ from flags");
`endif

endmodule

// File: dv/tilt_gesture_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// tilt_gesture_classifier_core_tb
// Self-checking bench for the tilt gesture classifier core. A scoreboard
// class predicts the tilt flags and the media command for every accepted
// sample word. Each result word is checked field by field against the oldest
// prediction. The run walks through several threshold and band settings,
// extremes among them. Directed gestures come first, then random samples
// that cluster around the thresholds and the band edges. The sender bursts
// with random gaps, and the receiver stalls at random, with a long hold-off
// now and then so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module tilt_gesture_classifier_core_tb;
  import tgc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 160;

  typedef struct packed {
    cmd_t command;
    logic right;
    logic left;
    logic fwd;
    logic back;
  } tilt_word_t;

  class tilt_scoreboard;
    logic [REG_W-1:0] x_thr;
    logic [REG_W-1:0] y_thr;
    logic [REG_W-1:0] band;
    logic right, left, fwd, back;
    tilt_word_t expected_words[$];
    int errors;

    function new();
      x_thr = X_THR_RST;
      y_thr = Y_THR_RST;
      band = BAND_RST;
      right = 1'b0;
      left = 1'b0;
      fwd = 1'b0;
      back = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        CFG_X_THR: x_thr = data;
        CFG_Y_THR: y_thr = data;
        CFG_BAND: band = data;
        default: ;
      endcase
    endfunction

    function cmd_t judge_tilt(input int v, input int thr, input int lvl,
                              inout logic pos, inout logic neg,
                              input cmd_t pos_cmd, input cmd_t neg_cmd);
      if (v > thr && !pos) begin
        pos = 1'b1;
        neg = 1'b0;
        return pos_cmd;
      end
      if (v < -thr && !neg) begin
        neg = 1'b1;
        pos = 1'b0;
        return neg_cmd;
      end
      if (v > -lvl && v < lvl) begin
        pos = 1'b0;
        neg = 1'b0;
      end
      return CMD_NONE;
    endfunction

    function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
      int xv, yv;
      cmd_t cmd, c;
      tilt_word_t w;
      xv = x;
      yv = y;
      cmd = CMD_NONE;
      if (!fwd && !back)
        cmd = judge_tilt(xv, int'(x_thr), int'(band), right, left, CMD_NEXT, CMD_PREV);
      if (!right && !left) begin
        c = judge_tilt(yv, int'(y_thr), int'(band), fwd, back, CMD_VOL_UP, CMD_VOL_DOWN);
        if (c != CMD_NONE) cmd = c;
      end
      w.command = cmd;
      w.right = right;
      w.left = left;
      w.fwd = fwd;
      w.back = back;
      expected_words.push_back(w);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [CMD_W-1:0] cmd, logic r, logic l, logic f, logic b);
      tilt_word_t w;
      if (expected_words.size() == 0) begin
        report("result word with no sample pending");
      end else begin
        w = expected_words.pop_front();
        if (cmd !== w.command)
          report($sformatf("command got %0d exp %0d", cmd, w.command));
        if (r !== w.right) report($sformatf("right_lit got %b exp %b", r, w.right));
        if (l !== w.left) report($sformatf("left_lit got %b exp %b", l, w.left));
        if (f !== w.fwd) report($sformatf("forward_lit got %b exp %b", f, w.fwd));
        if (b !== w.back) report($sformatf("back_lit got %b exp %b", b, w.back));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CMD_W-1:0] command;
  logic right_lit, left_lit, forward_lit, back_lit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  tilt_scoreboard sb;
  int burst_left = 1;

  tilt_gesture_classifier_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .command(command),
    .right_lit(right_lit),
    .left_lit(left_lit),
    .forward_lit(forward_lit),
    .back_lit(back_lit),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(command, right_lit, left_lit, forward_lit, back_lit);
  end

  // receiver stall pattern, with a periodic long hold-off
  initial begin
    int mode, span, cyc;
    cyc = 0;
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        cyc++;
        if (cyc % 3000 == 700) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task set_config(logic [REG_W-1:0] xt, logic [REG_W-1:0] yt, logic [REG_W-1:0] lvl);
    write_reg(CFG_X_THR, xt);
    write_reg(CFG_Y_THR, yt);
    write_reg(CFG_BAND, lvl);
    cfg_valid <= 1'b0;
  endtask

  task send_sample(logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    in_valid <= 1'b1;
    accel_x <= x;
    accel_y <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, y);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample(logic [REG_W-1:0] thr,
                                                      logic [REG_W-1:0] lvl);
    int v, t, b, off, neg;
    t = thr;
    b = lvl;
    off = $urandom_range(0, 4);
    off -= 2;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 6))
      0: begin
        v = $urandom_range(0, 65535);
        v -= 32768;
      end
      1: v = neg ? -(t + off) : t + off;
      2: v = neg ? -(b + off) : b + off;
      3: begin
        v = $urandom_range(0, 2 * b);
        v -= b;
      end
      4: v = neg ? -32768 : 32767;
      default: begin
        v = $urandom_range(0, 32767 - t);
        v = t + 1 + v;
        if (neg) v = -v;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task run_random(int n);
    logic signed [15:0] x, y;
    repeat (n) begin
      x = pick_sample(sb.x_thr, sb.band);
      y = pick_sample(sb.y_thr, sb.band);
      case ($urandom_range(0, 5))
        0: x = '0;
        1: y = '0;
        default: ;
      endcase
      send_sample(x, y);
    end
    drain();
  endtask

  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return REG_W'($urandom_range(0, 32767));
    return REG_W'($urandom_range(0, 8000));
  endfunction

  initial begin
    int guard;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: entries, holds, exact thresholds, band edges, axis lockout
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(32767, 0);
    send_sample(5001, 0);
    send_sample(499, 0);
    send_sample(-32768, 0);
    send_sample(5001, 0);
    send_sample(5000, 0);
    send_sample(-500, 0);
    send_sample(-499, 0);
    send_sample(-5000, 0);
    send_sample(-5001, 0);
    send_sample(500, 0);
    send_sample(0, 32767);
    send_sample(32767, 32767);
    send_sample(0, -32768);
    send_sample(0, 4501);
    send_sample(0, -499);
    send_sample(0, -4501);
    send_sample(0, 0);
    send_sample(32767, -32768);
    send_sample(0, 0);
    send_sample(-32768, -32768);
    send_sample(0, 4500);
    drain();

    // out-of-range index must be dropped
    write_reg(CFG_UNUSED, REG_W'($urandom_range(0, 32767)));
    set_config('0, '0, '0);
    run_random(180);

    set_config(15'h7fff, 15'h7fff, 15'h7fff);
    run_random(180);

    // band wider than threshold: held tilt still cleared by level test
    set_config(15'd1000, 15'd800, 15'd3000);
    send_sample(2000, 0);
    send_sample(2000, 0);
    send_sample(0, 900);
    send_sample(0, 900);
    send_sample(-1500, 0);
    run_random(180);

    set_config(X_THR_RST, Y_THR_RST, BAND_RST);
    run_random(210);

    repeat (4) begin
      set_config(pick_reg(), pick_reg(), pick_reg());
      run_random(200);
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0) begin
      $display("tb: failure");
    end else begin
      repeat (8) @(posedge clk);
      if (sb.errors == 0 && sb.pending() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tgc_pkg.sv
rtl/tgc_axis_judge.sv
rtl/tilt_gesture_classifier_core.sv
dv/tilt_gesture_classifier_core_tb.sv
